// ===== src/csstok_pkg.sv =====
// Shared types and constants for the style-sheet byte tokenizer.
// Used by the front classifier, the item queue, the lexer back end and the top level.
`timescale 1ns / 1ps

package csstok_pkg;

    // Token kinds as seen on the result channel
    localparam logic [3:0] KIND_UNDEF  = 4'd0;
    localparam logic [3:0] KIND_AT     = 4'd1;
    localparam logic [3:0] KIND_LINE   = 4'd2;
    localparam logic [3:0] KIND_CBEGIN = 4'd3;
    localparam logic [3:0] KIND_CEND   = 4'd4;
    localparam logic [3:0] KIND_LBRACE = 4'd5;
    localparam logic [3:0] KIND_RBRACE = 4'd6;
    localparam logic [3:0] KIND_COLON  = 4'd7;
    localparam logic [3:0] KIND_SEMI   = 4'd8;
    localparam logic [3:0] KIND_PAREN  = 4'd9;
    localparam logic [3:0] KIND_STRING = 4'd10;
    localparam logic [3:0] KIND_COMMA  = 4'd11;
    localparam logic [3:0] KIND_COLOUR = 4'd12;
    localparam logic [3:0] KIND_IDENT  = 4'd13;
    localparam logic [3:0] KIND_END    = 4'd14;

    // Characters with special meaning
    localparam logic [7:0] HASH_CHAR    = 8'h23;
    localparam logic [7:0] AT_CHAR      = 8'h40;
    localparam logic [7:0] PERCENT_CHAR = 8'h25;

    // Hex colour digit store
    localparam int         HEX_MAX   = 6;
    localparam logic [2:0] HEX_SHORT = 3'd3;
    localparam logic [2:0] HEX_LONG  = 3'd6;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character class found by the front end
    typedef enum logic [4:0] {
        CH_OTHER   = 5'd0,
        CH_WS      = 5'd1,
        CH_LF      = 5'd2,
        CH_SLASH   = 5'd3,
        CH_STAR    = 5'd4,
        CH_LPAREN  = 5'd5,
        CH_RPAREN  = 5'd6,
        CH_BSLASH  = 5'd7,
        CH_DQUOTE  = 5'd8,
        CH_SQUOTE  = 5'd9,
        CH_HASH    = 5'd10,
        CH_AT      = 5'd11,
        CH_LBRACE  = 5'd12,
        CH_RBRACE  = 5'd13,
        CH_COLON   = 5'd14,
        CH_SEMI    = 5'd15,
        CH_COMMA   = 5'd16,
        CH_PERCENT = 5'd17,
        CH_IDENT   = 5'd18
    } char_code_t;

    // One classified item in the queue
    typedef struct packed {
        logic       last;
        char_code_t code;
        logic       is_hex;
        logic [7:0] data;
    } entry_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/csstok_front.sv =====
// Front end of the tokenizer: input handshake and character classification.
// Depends on csstok_pkg; feeds the item queue.
`timescale 1ns / 1ps

module csstok_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] in_byte
    input  logic                      s_tlast,   // end_of_input
    input  csstok_pkg::queue_status_t q_status,
    output logic                      q_wr,
    output csstok_pkg::entry_t        q_wr_data
);
    import csstok_pkg::*;

    char_code_t code;
    logic       hex;

    // Byte class decoder
    always_comb begin
        unique case (s_tdata) inside
            8'h20, [8'h09:8'h09], [8'h0B:8'h0D]: code = CH_WS;
            8'h0A:                               code = CH_LF;
            8'h2F:                               code = CH_SLASH;
            8'h2A:                               code = CH_STAR;
            8'h28:                               code = CH_LPAREN;
            8'h29:                               code = CH_RPAREN;
            8'h5C:                               code = CH_BSLASH;
            8'h22:                               code = CH_DQUOTE;
            8'h27:                               code = CH_SQUOTE;
            HASH_CHAR:                           code = CH_HASH;
            AT_CHAR:                             code = CH_AT;
            8'h7B:                               code = CH_LBRACE;
            8'h7D:                               code = CH_RBRACE;
            8'h3A:                               code = CH_COLON;
            8'h3B:                               code = CH_SEMI;
            8'h2C:                               code = CH_COMMA;
            PERCENT_CHAR:                        code = CH_PERCENT;
            8'h2D, 8'h2E, [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]:
                                                 code = CH_IDENT;
            default:                             code = CH_OTHER;
        endcase
    end

    // Hex digit flag for colour lexing
    assign hex = ((s_tdata >= 8'h30) && (s_tdata <= 8'h39)) ||
                 ((s_tdata >= 8'h41) && (s_tdata <= 8'h46)) ||
                 ((s_tdata >= 8'h61) && (s_tdata <= 8'h66));

    assign s_tready = !q_status.full;
    assign q_wr     = s_tvalid && !q_status.full;

    always_comb begin
        q_wr_data.last   = s_tlast;
        q_wr_data.code   = code;
        q_wr_data.is_hex = hex;
        q_wr_data.data   = s_tdata;
    end

endmodule

// ===== src/csstok_fifo.sv =====
// Short item queue between the tokenizer front and back ends.
// Depends on csstok_pkg for the entry and status types.
`timescale 1ns / 1ps

module csstok_fifo #(
    parameter int DEPTH = csstok_pkg::QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr,
    input  csstok_pkg::entry_t        wr_data,
    input  logic                      rd,
    output csstok_pkg::entry_t        rd_data,
    output csstok_pkg::queue_status_t status
);
    import csstok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/csstok_back.sv =====
// Back end of the tokenizer: lexer state machine, hex digit store and output register.
// Depends on csstok_pkg; reads classified items from the queue.
`timescale 1ns / 1ps

module csstok_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  csstok_pkg::entry_t        head,
    input  csstok_pkg::queue_status_t q_status,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [7:0] token_byte
    output logic [4:0]                m_tuser,   // [0] byte_valid, [4:1] token_kind
    output logic                      m_tlast    // last_of_token
);
    import csstok_pkg::*;

    typedef enum logic [12:0] {
        M_IDLE       = 13'b0000000000001,
        M_SLASH      = 13'b0000000000010,
        M_STAR       = 13'b0000000000100,
        M_LINE       = 13'b0000000001000,
        M_PAREN      = 13'b0000000010000,
        M_PAREN_ESC  = 13'b0000000100000,
        M_STRING     = 13'b0000001000000,
        M_STRING_ESC = 13'b0000010000000,
        M_HASH       = 13'b0000100000000,
        M_IDENT      = 13'b0001000000000,
        M_FLUSH      = 13'b0010000000000,
        M_COLOUR     = 13'b0100000000000,
        M_FALLBACK   = 13'b1000000000000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic [3:0] held_kind_reg, held_kind_next;
    logic       held_valid_reg, held_valid_next;
    logic       quote_dbl_reg, quote_dbl_next;
    logic [2:0] hex_count_reg, hex_count_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] hex_digits_reg [HEX_MAX];

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg;
    logic [3:0] out_kind_reg;
    logic       out_last_reg;

    logic       slot, go_in, dig_we, emit, e_bv, e_last, quote_hit, seq_last;
    logic [7:0] e_byte, dig;
    logic [3:0] e_kind, punct_kind;
    logic [2:0] rd_idx;

    // Output register can take a result this cycle
    assign slot  = !out_valid_reg || m_tready;
    assign go_in = slot && !q_status.empty;

    // Kind of a single-byte token
    always_comb begin
        unique case (head.code)
            CH_AT:     punct_kind = KIND_AT;
            CH_LBRACE: punct_kind = KIND_LBRACE;
            CH_RBRACE: punct_kind = KIND_RBRACE;
            CH_COLON:  punct_kind = KIND_COLON;
            CH_SEMI:   punct_kind = KIND_SEMI;
            CH_COMMA:  punct_kind = KIND_COMMA;
            default:   punct_kind = KIND_UNDEF;
        endcase
    end

    // Closing quote matches the opening one
    assign quote_hit = quote_dbl_reg ? (head.code == CH_DQUOTE) : (head.code == CH_SQUOTE);

    // Digit store read port
    assign rd_idx   = (mode_reg == M_HASH) ? 3'd0 : idx_reg;
    assign dig      = hex_digits_reg[rd_idx];
    assign seq_last = ((idx_reg + 3'd1) == hex_count_reg);

    // Lexer step: at most one result per cycle
    always_comb begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_kind_next  = held_kind_reg;
        held_valid_next = held_valid_reg;
        quote_dbl_next  = quote_dbl_reg;
        hex_count_next  = hex_count_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;
        dig_we          = 1'b0;
        emit            = 1'b0;
        e_byte          = held_byte_reg;
        e_kind          = held_kind_reg;
        e_bv            = 1'b1;
        e_last          = 1'b0;

        unique case (mode_reg)
            M_IDLE: begin
                if (go_in) begin
                    pop = 1'b1;
                    if (head.last) begin
                        // empty end token, back to reset state
                        emit            = 1'b1;
                        e_byte          = 8'd0;
                        e_bv            = 1'b0;
                        e_kind          = KIND_END;
                        e_last          = 1'b1;
                        held_byte_next  = 8'd0;
                        held_kind_next  = KIND_UNDEF;
                        held_valid_next = 1'b0;
                        quote_dbl_next  = 1'b0;
                        hex_count_next  = 3'd0;
                    end else begin
                        case (head.code) inside
                            CH_WS, CH_LF: begin
                            end
                            CH_SLASH: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_UNDEF;
                                held_valid_next = 1'b1;
                                mode_next       = M_SLASH;
                            end
                            CH_STAR: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_UNDEF;
                                held_valid_next = 1'b1;
                                mode_next       = M_STAR;
                            end
                            CH_LPAREN: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_PAREN;
                                held_valid_next = 1'b1;
                                mode_next       = M_PAREN;
                            end
                            CH_DQUOTE, CH_SQUOTE: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_STRING;
                                held_valid_next = 1'b1;
                                quote_dbl_next  = (head.code == CH_DQUOTE);
                                mode_next       = M_STRING;
                            end
                            CH_HASH: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_UNDEF;
                                held_valid_next = 1'b1;
                                hex_count_next  = 3'd0;
                                mode_next       = M_HASH;
                            end
                            CH_IDENT: begin
                                held_byte_next  = head.data;
                                held_kind_next  = KIND_IDENT;
                                held_valid_next = 1'b1;
                                mode_next       = M_IDENT;
                            end
                            default: begin
                                // single-byte token: punctuation or undefined
                                emit   = 1'b1;
                                e_byte = head.data;
                                e_kind = punct_kind;
                                e_last = 1'b1;
                            end
                        endcase
                    end
                end
            end
            M_SLASH: begin
                if (go_in) begin
                    if (!head.last && head.code == CH_SLASH) begin
                        emit           = 1'b1;
                        e_kind         = KIND_LINE;
                        held_byte_next = head.data;
                        held_kind_next = KIND_LINE;
                        mode_next      = M_LINE;
                        pop            = 1'b1;
                    end else if (!head.last && head.code == CH_STAR) begin
                        emit           = 1'b1;
                        e_kind         = KIND_CBEGIN;
                        held_byte_next = head.data;
                        held_kind_next = KIND_CBEGIN;
                        mode_next      = M_FLUSH;
                        pop            = 1'b1;
                    end else begin
                        // lone slash; the byte is lexed again from idle
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                    end
                end
            end
            M_STAR: begin
                if (go_in) begin
                    if (!head.last && head.code == CH_SLASH) begin
                        emit           = 1'b1;
                        e_kind         = KIND_CEND;
                        held_byte_next = head.data;
                        held_kind_next = KIND_CEND;
                        mode_next      = M_FLUSH;
                        pop            = 1'b1;
                    end else begin
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                    end
                end
            end
            M_LINE: begin
                if (go_in) begin
                    if (head.last || head.code == CH_LF) begin
                        // newline is consumed, not part of the comment
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                        pop             = !head.last;
                    end else begin
                        emit           = held_valid_reg;
                        held_byte_next = head.data;
                        pop            = 1'b1;
                    end
                end
            end
            M_PAREN, M_STRING: begin
                if (go_in) begin
                    if (head.last) begin
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                    end else if (head.code == CH_BSLASH) begin
                        mode_next = (mode_reg == M_PAREN) ? M_PAREN_ESC : M_STRING_ESC;
                        pop       = 1'b1;
                    end else begin
                        emit           = held_valid_reg;
                        held_byte_next = head.data;
                        pop            = 1'b1;
                        // closing byte: hold it, then flush it from the flush state
                        if ((mode_reg == M_PAREN && head.code == CH_RPAREN) ||
                            (mode_reg == M_STRING && quote_hit)) begin
                            mode_next = M_FLUSH;
                        end
                    end
                end
            end
            M_PAREN_ESC, M_STRING_ESC: begin
                if (go_in) begin
                    if (head.last) begin
                        // dangling backslash is dropped
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                    end else begin
                        emit           = held_valid_reg;
                        held_byte_next = head.data;
                        mode_next      = (mode_reg == M_PAREN_ESC) ? M_PAREN : M_STRING;
                        pop            = 1'b1;
                    end
                end
            end
            M_HASH: begin
                if (go_in) begin
                    if (!head.last && head.is_hex && hex_count_reg < HEX_LONG) begin
                        dig_we         = 1'b1;
                        hex_count_next = hex_count_reg + 3'd1;
                        pop            = 1'b1;
                    end else if ((head.last || !head.is_hex) &&
                                 (hex_count_reg == HEX_SHORT || hex_count_reg == HEX_LONG)) begin
                        // colour: '#' now, digits from the store next
                        emit            = 1'b1;
                        e_byte          = HASH_CHAR;
                        e_kind          = KIND_COLOUR;
                        held_valid_next = 1'b0;
                        idx_next        = 3'd0;
                        mode_next       = M_COLOUR;
                    end else begin
                        // fallback: '#' alone, digits become an identifier
                        emit   = 1'b1;
                        e_byte = HASH_CHAR;
                        e_kind = KIND_UNDEF;
                        e_last = 1'b1;
                        if (hex_count_reg == 3'd0) begin
                            held_valid_next = 1'b0;
                            mode_next       = M_IDLE;
                        end else begin
                            held_byte_next  = dig;
                            held_kind_next  = KIND_IDENT;
                            held_valid_next = 1'b1;
                            idx_next        = 3'd1;
                            if (hex_count_reg == 3'd1) begin
                                hex_count_next = 3'd0;
                                mode_next      = M_IDENT;
                            end else begin
                                mode_next = M_FALLBACK;
                            end
                        end
                    end
                end
            end
            M_COLOUR: begin
                if (slot) begin
                    emit     = 1'b1;
                    e_byte   = dig;
                    e_kind   = KIND_COLOUR;
                    e_last   = seq_last;
                    idx_next = idx_reg + 3'd1;
                    if (seq_last) begin
                        hex_count_next = 3'd0;
                        mode_next      = M_IDLE;
                    end
                end
            end
            M_FALLBACK: begin
                if (slot) begin
                    emit           = held_valid_reg;
                    held_byte_next = dig;
                    idx_next       = idx_reg + 3'd1;
                    if (seq_last) begin
                        hex_count_next = 3'd0;
                        mode_next      = M_IDENT;
                    end
                end
            end
            M_IDENT: begin
                if (go_in) begin
                    if (!head.last && (head.code == CH_IDENT || head.code == CH_PERCENT)) begin
                        emit           = held_valid_reg;
                        held_byte_next = head.data;
                        pop            = 1'b1;
                    end else begin
                        emit            = held_valid_reg;
                        e_last          = 1'b1;
                        held_valid_next = 1'b0;
                        mode_next       = M_IDLE;
                    end
                end
            end
            M_FLUSH: begin
                if (slot) begin
                    emit            = held_valid_reg;
                    e_last          = 1'b1;
                    held_valid_next = 1'b0;
                    mode_next       = M_IDLE;
                end
            end
            default: begin
                mode_next = M_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= KIND_UNDEF;
            held_byte_reg  <= 8'd0;
            quote_dbl_reg  <= 1'b0;
            hex_count_reg  <= 3'd0;
            idx_reg        <= 3'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            held_valid_reg <= held_valid_next;
            held_kind_reg  <= held_kind_next;
            held_byte_reg  <= held_byte_next;
            quote_dbl_reg  <= quote_dbl_next;
            hex_count_reg  <= hex_count_next;
            idx_reg        <= idx_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: output register and digit store
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg <= e_byte;
            out_bv_reg   <= e_bv;
            out_kind_reg <= e_kind;
            out_last_reg <= e_last;
        end
        if (dig_we) begin
            hex_digits_reg[hex_count_reg] <= head.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_kind_reg, out_bv_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/css_byte_tokenizer.sv =====
// Top level of the style-sheet byte tokenizer: front classifier, item queue, lexer back end.
// Depends on csstok_pkg, csstok_front, csstok_fifo and csstok_back.
//
// Usage:
//   Input channel s_*: one text byte per item in s_tdata[7:0]; s_tlast marks the
//   end of text (the byte is then ignored). Result channel m_*: one token byte per
//   item in m_tdata[7:0], m_tuser[0] = byte valid, m_tuser[4:1] = token kind,
//   m_tlast = last byte of the token. End of text gives pending tokens, then an
//   empty end token (byte valid 0, kind end).
// Timing:
//   Bytes are classified on entry and go through a FIFO_DEPTH-entry queue. The
//   lexer back end handles one queued byte per cycle while the output register can
//   take a result and it is not flushing or emitting stored digits, and drives at
//   most one result per cycle into the output register. A byte that closes an open
//   token is lexed again from idle; a closing bracket, quote or comment-begin/-end
//   pair passes through the flush state; a hex colour or fallback steps through its
//   stored digits (up to 6). Each byte is queued, then lexed into the output register.
// Reset and stall:
//   aresetn (synchronous, active low) empties the queue and returns the lexer to
//   idle between tokens. When m_tready is low the result is held; the lexer stops
//   and the queue fills, after which s_tready drops.
`timescale 1ns / 1ps

module css_byte_tokenizer #(
    parameter int FIFO_DEPTH = csstok_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_byte
    output logic [4:0] m_tuser,   // [0] byte_valid, [4:1] token_kind
    output logic       m_tlast    // last_of_token
);
    import csstok_pkg::*;

    logic          q_wr, q_rd;
    entry_t        q_wr_data, q_head;
    queue_status_t q_status;

    csstok_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data)
    );

    csstok_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_head),
        .status  (q_status)
    );

    csstok_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Only the end token carries no byte, and it always closes
    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[4:1] == KIND_END && m_tlast))
        else $error("result without byte is not a closing end token");

    // No kind code beyond the end token
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[4:1] <= KIND_END))
        else $error("token kind out of range");

    // A write without a pop leaves the queue non-empty in the next cycle
    a_queue_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr && !q_rd) |=> !q_status.empty)
        else $error("queue lost a written item");

    // Back end never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
